// ----- hw/rtl/pairwise_genotype_mismatch_count_unit_assert.svh -----
// Assertion macros for the pairwise genotype mismatch count unit.
`ifndef PAIRWISE_GENOTYPE_MISMATCH_COUNT_UNIT_ASSERT_SVH
`define PAIRWISE_GENOTYPE_MISMATCH_COUNT_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PGMU_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgmu assertion failed");

// next-cycle implication
`define PGMU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgmu assertion failed");

`endif

// ----- hw/rtl/pgm_pkg.sv -----
// Shared types and constants of the pairwise genotype mismatch count unit.
`default_nettype none

package pgm_pkg;

    localparam int MAX_INDIVIDUALS_DEF = 8;
    localparam int COUNT_BITS_DEF      = 16;
    localparam int GENO_W              = 8;
    localparam int SIZE_W              = 3;
    localparam int TOTAL_W             = SIZE_W + 1;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] GROUP_A_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] GROUP_B_RESET = 3'd4;

    localparam logic REG_GROUP_A = 1'b0;
    localparam logic REG_GROUP_B = 1'b1;

    localparam logic signed [2*GENO_W-1:0] MISMATCH_PRODUCT = -16'sd9;

    typedef struct packed {
        logic signed [GENO_W-1:0] genotype;
        logic                     last_in_window;
    } item_t;

    // slot = row*(row-1)/2 + col
    function automatic int pair_row(input int slot);
        int row;
        int rem;
        row = 1;
        rem = slot;
        for (int k = 0; k < 64; k++)
        begin
            if (rem >= row)
            begin
                rem = rem - row;
                row = row + 1;
            end
        end
        return row;
    endfunction

    function automatic int pair_col(input int slot);
        int row;
        int rem;
        row = 1;
        rem = slot;
        for (int k = 0; k < 64; k++)
        begin
            if (rem >= row)
            begin
                rem = rem - row;
                row = row + 1;
            end
        end
        return rem;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pairwise_genotype_mismatch_count_unit.sv -----
// Top level of the pairwise genotype mismatch count unit.
// Takes one genotype code per clock while busy is low; a four-item queue sits in
// front of the counting engine, which counts each code at the edge that takes it
// from the queue. On an item flagged last_in_window the engine enters its emit
// state and emits every pair count, m*(m-1)/2 results for m individuals, on
// consecutive cycles through the output registers; it takes no items while it
// emits, so busy rises once the queue fills. The receiver cannot stall: each
// result is valid for the single cycle in which strobe is high. Write the group
// sizes only while idle.
`default_nettype none

module pairwise_genotype_mismatch_count_unit
#(
    parameter int MAX_INDIVIDUALS = pgm_pkg::MAX_INDIVIDUALS_DEF,
    parameter int COUNT_BITS      = pgm_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [pgm_pkg::GENO_W-1:0]     genotype,
    input  wire logic                                  last_in_window,
    input  wire logic                                  write_enable,
    input  wire logic                                  register_index,
    input  wire logic [pgm_pkg::SIZE_W-1:0]            write_data,
    output logic                                       strobe,
    output logic [$clog2(MAX_INDIVIDUALS)-1:0]         row_individual,
    output logic [$clog2(MAX_INDIVIDUALS)-1:0]         column_individual,
    output logic [COUNT_BITS-1:0]                      pair_count,
    output logic                                       last_result
);

    logic [pgm_pkg::SIZE_W-1:0] group_a_reg, group_a_next;
    logic [pgm_pkg::SIZE_W-1:0] group_b_reg, group_b_next;
    pgm_pkg::item_t             head;
    logic                       head_valid;
    logic                       pop;

    always_comb
    begin
        group_a_next = group_a_reg;
        group_b_next = group_b_reg;
        if (write_enable)
        begin
            unique case (register_index)
                pgm_pkg::REG_GROUP_A: group_a_next = write_data;
                pgm_pkg::REG_GROUP_B: group_b_next = write_data;
                default:              group_a_next = group_a_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_a_reg <= pgm_pkg::GROUP_A_RESET;
            group_b_reg <= pgm_pkg::GROUP_B_RESET;
        end
        else
        begin
            group_a_reg <= group_a_next;
            group_b_reg <= group_b_next;
        end
    end

    pgm_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .genotype       (genotype),
        .last_in_window (last_in_window),
        .busy           (busy),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    pgm_back
    #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
        .COUNT_BITS      (COUNT_BITS)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .group_a_size      (group_a_reg),
        .group_b_size      (group_b_reg),
        .head              (head),
        .head_valid        (head_valid),
        .pop               (pop),
        .strobe            (strobe),
        .row_individual    (row_individual),
        .column_individual (column_individual),
        .pair_count        (pair_count),
        .last_result       (last_result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pgm_front.sv -----
// Front end: takes items and holds them in a short queue for the back end.
`default_nettype none

module pgm_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [pgm_pkg::GENO_W-1:0] genotype,
    input  wire logic                             last_in_window,
    output logic                                  busy,
    output pgm_pkg::item_t                        head,
    output logic                                  head_valid,
    input  wire logic                             pop
);

    pgm_pkg::item_t                   queue_reg [pgm_pkg::QUEUE_DEPTH];
    logic [pgm_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [pgm_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [pgm_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             push;
    pgm_pkg::item_t                   in_item;

    assign busy       = (count_reg == pgm_pkg::QCNT_W'(pgm_pkg::QUEUE_DEPTH));
    assign push       = start && !busy;
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.genotype       = genotype;
        in_item.last_in_window = last_in_window;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + pgm_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + pgm_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + pgm_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - pgm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pgm_back.sv -----
// Back end: compares each code against the position's codes, counts, emits pair counts.
`default_nettype none

module pgm_back
#(
    parameter int MAX_INDIVIDUALS = pgm_pkg::MAX_INDIVIDUALS_DEF,
    parameter int COUNT_BITS      = pgm_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [pgm_pkg::SIZE_W-1:0]           group_a_size,
    input  wire logic [pgm_pkg::SIZE_W-1:0]           group_b_size,
    input  pgm_pkg::item_t                            head,
    input  wire logic                                 head_valid,
    output logic                                      pop,
    output logic                                      strobe,
    output logic [$clog2(MAX_INDIVIDUALS)-1:0]        row_individual,
    output logic [$clog2(MAX_INDIVIDUALS)-1:0]        column_individual,
    output logic [COUNT_BITS-1:0]                     pair_count,
    output logic                                      last_result
);

    localparam int IDX_W      = $clog2(MAX_INDIVIDUALS);
    localparam int LANES      = MAX_INDIVIDUALS - 1;
    localparam int PAIR_SLOTS = MAX_INDIVIDUALS * (MAX_INDIVIDUALS - 1) / 2;
    localparam int TW         = pgm_pkg::TOTAL_W;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                            state_reg, state_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [IDX_W-1:0]                row_reg, row_next;
    logic [IDX_W-1:0]                col_reg, col_next;
    logic signed [pgm_pkg::GENO_W-1:0] codes_reg [MAX_INDIVIDUALS];
    logic [COUNT_BITS-1:0]           cnt_reg [PAIR_SLOTS];

    logic                            strobe_reg;
    logic [IDX_W-1:0]                row_out_reg;
    logic [IDX_W-1:0]                col_out_reg;
    logic [COUNT_BITS-1:0]           count_out_reg;
    logic                            last_out_reg;

    logic [TW-1:0]                   sum;
    logic [TW-1:0]                   total;
    logic [IDX_W-1:0]                idx_cur;
    logic [TW-1:0]                   idx_inc;
    logic                            fire;
    logic                            emit_last;
    logic                            clear_all;
    logic                            shift;
    logic [LANES-1:0]                match;

    assign sum = TW'(group_a_size) + TW'(group_b_size);

    always_comb
    begin
        if (sum == '0)
        begin
            total = TW'(1);
        end
        else if (sum > TW'(MAX_INDIVIDUALS))
        begin
            total = TW'(MAX_INDIVIDUALS);
        end
        else
        begin
            total = sum;
        end
    end

    assign pop       = head_valid && (state_reg == ST_RUN);
    assign fire      = pop;
    assign idx_cur   = (TW'(idx_reg) >= total) ? '0 : idx_reg;
    assign idx_inc   = TW'(idx_cur) + TW'(1);
    assign emit_last = (TW'(row_reg) == total - TW'(1)) && (col_reg == row_reg - IDX_W'(1));
    assign shift     = (state_reg == ST_EMIT) && !emit_last;
    assign clear_all = ((state_reg == ST_EMIT) && emit_last)
                    || (fire && head.last_in_window && (total < TW'(2)));

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [2*pgm_pkg::GENO_W-1:0] prod;
        assign prod     = $signed(head.genotype) * $signed(codes_reg[l]);
        assign match[l] = (prod == pgm_pkg::MISMATCH_PRODUCT);
    end

    for (genvar s = 0; s < PAIR_SLOTS; s++)
    begin : g_slot
        localparam int ROW = pgm_pkg::pair_row(s);
        localparam int COL = pgm_pkg::pair_col(s);
        logic                  inc;
        logic [COUNT_BITS-1:0] shift_src;

        assign inc = fire && (idx_cur == IDX_W'(ROW)) && match[COL];

        if (s == PAIR_SLOTS - 1)
        begin : g_top
            assign shift_src = '0;
        end
        else
        begin : g_mid
            assign shift_src = cnt_reg[s+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[s] <= '0;
            end
            else if (clear_all)
            begin
                cnt_reg[s] <= '0;
            end
            else if (shift)
            begin
                cnt_reg[s] <= shift_src;
            end
            else if (inc && (cnt_reg[s] != '1))
            begin
                cnt_reg[s] <= cnt_reg[s] + COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (fire)
                begin
                    if (head.last_in_window || (idx_inc >= total))
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_inc[IDX_W-1:0];
                    end
                    if (head.last_in_window && (total >= TW'(2)))
                    begin
                        state_next = ST_EMIT;
                        row_next   = IDX_W'(1);
                        col_next   = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_RUN;
                end
                else if (col_reg == row_reg - IDX_W'(1))
                begin
                    row_next = row_reg + IDX_W'(1);
                    col_next = '0;
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            idx_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            strobe_reg <= (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            codes_reg[idx_cur] <= head.genotype;
        end
        row_out_reg   <= row_reg;
        col_out_reg   <= col_reg;
        count_out_reg <= cnt_reg[0];
        last_out_reg  <= emit_last;
    end

    assign strobe            = strobe_reg;
    assign row_individual    = row_out_reg;
    assign column_individual = col_out_reg;
    assign pair_count        = count_out_reg;
    assign last_result       = strobe_reg && last_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pgm_checker.sv -----
// Port-level checks on the emitted result stream (strobe, indices, last flag), bound to the top level.
`default_nettype none

`include "pairwise_genotype_mismatch_count_unit_assert.svh"

module pgm_checker
#(
    parameter int MAX_INDIVIDUALS = pgm_pkg::MAX_INDIVIDUALS_DEF,
    parameter int COUNT_BITS      = pgm_pkg::COUNT_BITS_DEF
)
(
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 strobe,
    input wire logic [$clog2(MAX_INDIVIDUALS)-1:0]   row_individual,
    input wire logic [$clog2(MAX_INDIVIDUALS)-1:0]   column_individual,
    input wire logic [COUNT_BITS-1:0]                pair_count,
    input wire logic                                 last_result
);

    localparam int IDX_W = $clog2(MAX_INDIVIDUALS);

    logic [IDX_W-1:0] row_prev_reg;
    logic [IDX_W-1:0] col_prev_reg;
    logic             col_step;
    logic             row_step;

    always_ff @(posedge clk)
    begin
        row_prev_reg <= row_individual;
        col_prev_reg <= column_individual;
    end

    assign col_step = (row_individual == row_prev_reg)
                   && (column_individual == col_prev_reg + IDX_W'(1));
    assign row_step = (row_individual == row_prev_reg + IDX_W'(1))
                   && (column_individual == '0);

    `PGMU_ASSERT_IMPL(a_last_has_strobe, last_result, strobe)
    `PGMU_ASSERT_IMPL(a_row_above_col, strobe, row_individual > column_individual)
    `PGMU_ASSERT_NEXT(a_burst_unbroken, strobe && !last_result, strobe)
    `PGMU_ASSERT_NEXT(a_burst_ends, strobe && last_result, !strobe)
    `PGMU_ASSERT_NEXT(a_pair_order, strobe && !last_result, col_step || row_step)

endmodule

bind pairwise_genotype_mismatch_count_unit pgm_checker
#(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
    .COUNT_BITS      (COUNT_BITS)
)
u_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .strobe            (strobe),
    .row_individual    (row_individual),
    .column_individual (column_individual),
    .pair_count        (pair_count),
    .last_result       (last_result)
);

`default_nettype wire
